[hw/rtl/point_in_triangle_projection_top_defines.svh]
// Assertion macros for the point-in-triangle block.
// Used by modules that carry i_clk and i_rst_n; no other dependencies.
`ifndef POINT_IN_TRIANGLE_PROJECTION_TOP_DEFINES_SVH
`define POINT_IN_TRIANGLE_PROJECTION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pit: assertion failed");
`define PIT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pit: assertion failed");
`else
`define PIT_ASSERT_IMP(lbl, ante, cons)
`define PIT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/pit_pkg.sv]
// Shared types, widths and constants of the point-in-triangle pipeline.
// No dependencies.
package pit_pkg;

    localparam int CW   = 16;          // Q8.8 coordinate
    localparam int DW   = 17;          // edge vector component
    localparam int XW   = 35;          // cross product component
    localparam int HALF = 17;          // low split of a cross component
    localparam int HW   = XW - HALF + 1;
    localparam int PW   = HW + XW;     // partial product
    localparam int FW   = 2 * XW;      // full dot-product term
    localparam int SW   = FW + 2;      // dot product
    localparam int NW   = SW + 15;     // rounded numerator, 14 fraction bits
    localparam int DDW  = SW - 1;      // |n|^2
    localparam int QW   = 31;          // weight magnitude
    localparam int WW   = 35;          // signed weight
    localparam int BW   = WW + CW;     // blend product
    localparam int BSW  = BW + 2;      // blend sum
    localparam int RW   = BSW - 14;    // rounded blend

    localparam logic signed [WW-1:0] WEIGHT_ONE = WW'(16384);
    localparam logic signed [WW-1:0] WEIGHT_CAP = WW'(32'h7FFF_FFFF);

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord p0 [3];
        t_coord p1 [3];
        t_coord p2 [3];
        logic   degen;
    } t_side;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

[hw/rtl/pit_if.sv]
// Request and result channels of the point-in-triangle block.
// Depends on pit_pkg.
interface pit_in_if import pit_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vert0_x, vert0_y, vert0_z;
    t_coord vert1_x, vert1_y, vert1_z;
    t_coord vert2_x, vert2_y, vert2_z;
    t_coord query_x, query_y, query_z;

    modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                    vert2_x, vert2_y, vert2_z, query_x, query_y, query_z, input ready);
    modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, query_x, query_y, query_z, output ready);
endinterface

interface pit_out_if import pit_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   inside_res;
    t_coord proj_x, proj_y, proj_z;
    logic   degenerate;

    modport source (output valid, inside_res, proj_x, proj_y, proj_z, degenerate,
                    input ready);
    modport sink (input valid, inside_res, proj_x, proj_y, proj_z, degenerate,
                  output ready);
endinterface

[hw/rtl/pit_front.sv]
// Front end: edge vectors, cross products, dot products and division operands.
// Six register stages. Depends on pit_pkg.
module pit_front import pit_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  t_side             i_side,
    input  t_coord            i_query [3],
    output logic              o_valid,
    output t_side             o_side,
    output logic [NW-1:0]     o_num [2],
    output logic              o_neg [2],
    output logic [DDW-1:0]    o_den
);

    localparam int STAGES = 6;

    function automatic logic signed [XW-1:0] cross_term(
        input logic signed [DW-1:0] a, b, c, d);
        logic signed [2*DW-1:0] p, q;
        p = a * b;
        q = c * d;
        return XW'(p) - XW'(q);
    endfunction

    logic [STAGES-1:0] r_vld;
    t_side r_side [STAGES];

    logic signed [DW-1:0] r_u [3], r_v [3], r_w [3];
    logic signed [XW-1:0] r_n [3], r_cu [3], r_cb [3];
    logic signed [PW-1:0] r_ph [3][3], r_pl [3][3];
    logic signed [FW-1:0] r_prod [3][3];
    logic signed [SW-1:0] r_dot [3];
    logic [NW-1:0]        r_num [2];
    logic                 r_neg [2];
    logic [DDW-1:0]       r_den;

    logic signed [XW-1:0] lhs [3][3];
    logic signed [HW-1:0] lhs_hi [3][3], lhs_lo [3][3];
    logic [NW-1:0]        n_num [2];
    logic                 n_neg [2];
    t_side                n_side_out;

    // operand split so each multiplier stays near 18x35
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lhs[0][k] = r_n[k];
            lhs[1][k] = r_cu[k];
            lhs[2][k] = r_cb[k];
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                lhs_hi[j][k] = HW'($signed(lhs[j][k][XW-1:HALF]));
                lhs_lo[j][k] = HW'($signed({1'b0, lhs[j][k][HALF-1:0]}));
            end
        end
    end

    // |num| << 14 plus half the divisor: round to nearest, ties away from zero
    always_comb begin
        logic [SW-1:0] mag;
        mag = '0;
        for (int j = 0; j < 2; j++) begin
            n_neg[j] = r_dot[j+1][SW-1];
            mag = n_neg[j] ? SW'(-r_dot[j+1]) : SW'(r_dot[j+1]);
            n_num[j] = NW'({mag, 14'b0}) + NW'(r_dot[0][DDW-1:1]);
        end
    end

    // zero normal flagged as the request leaves
    always_comb begin
        n_side_out       = r_side[STAGES-2];
        n_side_out.degen = (r_dot[0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[STAGES-2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < STAGES - 1; s++) r_side[s] <= r_side[s-1];
            r_side[STAGES-1] <= n_side_out;

            for (int k = 0; k < 3; k++) begin
                r_u[k] <= DW'(i_side.p1[k]) - DW'(i_side.p0[k]);
                r_v[k] <= DW'(i_side.p2[k]) - DW'(i_side.p0[k]);
                r_w[k] <= DW'(i_query[k]) - DW'(i_side.p0[k]);
            end

            r_n[0]  <= cross_term(r_u[1], r_v[2], r_u[2], r_v[1]);
            r_n[1]  <= cross_term(r_u[2], r_v[0], r_u[0], r_v[2]);
            r_n[2]  <= cross_term(r_u[0], r_v[1], r_u[1], r_v[0]);
            r_cu[0] <= cross_term(r_u[1], r_w[2], r_u[2], r_w[1]);
            r_cu[1] <= cross_term(r_u[2], r_w[0], r_u[0], r_w[2]);
            r_cu[2] <= cross_term(r_u[0], r_w[1], r_u[1], r_w[0]);
            r_cb[0] <= cross_term(r_w[1], r_v[2], r_w[2], r_v[1]);
            r_cb[1] <= cross_term(r_w[2], r_v[0], r_w[0], r_v[2]);
            r_cb[2] <= cross_term(r_w[0], r_v[1], r_w[1], r_v[0]);

            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_ph[j][k]   <= PW'(lhs_hi[j][k]) * PW'(r_n[k]);
                    r_pl[j][k]   <= PW'(lhs_lo[j][k]) * PW'(r_n[k]);
                    r_prod[j][k] <= (FW'(r_ph[j][k]) <<< HALF) + FW'(r_pl[j][k]);
                end
                r_dot[j] <= SW'(r_prod[j][0]) + SW'(r_prod[j][1]) + SW'(r_prod[j][2]);
            end

            for (int j = 0; j < 2; j++) begin
                r_num[j] <= n_num[j];
                r_neg[j] <= n_neg[j];
            end
            r_den <= r_dot[0][DDW-1:0];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_num   = r_num;
    assign o_neg   = r_neg;
    assign o_den   = r_den;

endmodule

[hw/rtl/pit_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage,
// with an overflow check in front. Depends on pit_pkg.
module pit_div import pit_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_pipe_ctl      i_ctl,
    input  t_side          i_side,
    input  logic [NW-1:0]  i_num [2],
    input  logic           i_neg [2],
    input  logic [DDW-1:0] i_den,
    output logic           o_valid,
    output t_side          o_side,
    output logic [QW-1:0]  o_q [2],
    output logic           o_sat [2],
    output logic           o_neg [2]
);

    localparam int STAGES = QW + 1;
    localparam int WDS    = DDW + QW;

    logic [STAGES-1:0] r_vld;
    t_side             r_side [STAGES];
    logic [DDW-1:0]    r_den  [STAGES];
    logic [NW-1:0]     r_rem  [STAGES][2];
    logic [QW-1:0]     r_q    [STAGES][2];
    logic              r_sat  [STAGES][2];
    logic              r_neg  [STAGES][2];

    logic [NW-1:0] n_rem [STAGES][2];
    logic [QW-1:0] n_q   [STAGES][2];

    // stage s decides quotient bit QW-s
    always_comb begin
        logic [WDS-1:0] ds;
        ds = '0;
        for (int l = 0; l < 2; l++) begin
            n_rem[0][l] = i_num[l];
            n_q[0][l]   = '0;
        end
        for (int s = 1; s < STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
                ds = WDS'(r_den[s-1]) << (QW - s);
                if (WDS'(r_rem[s-1][l]) >= ds) begin
                    n_rem[s][l] = r_rem[s-1][l] - ds[NW-1:0];
                    n_q[s][l]   = r_q[s-1][l] | (QW'(1) << (QW - s));
                end else begin
                    n_rem[s][l] = r_rem[s-1][l];
                    n_q[s][l]   = r_q[s-1][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[STAGES-2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            for (int l = 0; l < 2; l++) begin
                r_sat[0][l] <= (WDS'(i_num[l]) >= (WDS'(i_den) << QW));
                r_neg[0][l] <= i_neg[l];
            end
            for (int s = 1; s < STAGES; s++) begin
                r_side[s] <= r_side[s-1];
                r_den[s]  <= r_den[s-1];
                for (int l = 0; l < 2; l++) begin
                    r_sat[s][l] <= r_sat[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                end
            end
            for (int s = 0; s < STAGES; s++) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            o_q[l]   = r_q[STAGES-1][l];
            o_sat[l] = r_sat[STAGES-1][l];
            o_neg[l] = r_neg[STAGES-1][l];
        end
    end

endmodule

[hw/rtl/pit_blend.sv]
// Back end: signed weights, tolerance test, vertex blend, rounding and
// saturation into the output register. Depends on pit_pkg.
module pit_blend import pit_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_pipe_ctl     i_ctl,
    input  t_side         i_side,
    input  logic [QW-1:0] i_q [2],
    input  logic          i_sat [2],
    input  logic          i_neg [2],
    input  logic [15:0]   i_tol,
    output logic          o_valid,
    output logic          o_inside,
    output t_coord        o_proj [3],
    output logic          o_degen
);

    localparam int STAGES = 5;
    localparam logic signed [RW-1:0] PROJ_MAX = RW'(32767);
    localparam logic signed [RW-1:0] PROJ_MIN = -RW'(32768);

    logic [STAGES-1:0] r_vld;
    t_side             r_side [STAGES-1];

    logic signed [WW-1:0]  r1_l, r1_b, r2_l, r2_b, r2_a;
    logic                  r3_inside, r4_inside;
    logic signed [BW-1:0]  r3_pa [3], r3_pb [3], r3_pl [3];
    logic signed [RW-1:0]  r4_r [3];
    logic                  r_inside, r_degen;
    t_coord                r_proj [3];

    logic signed [WW-1:0]  n_w [2];
    logic signed [WW-1:0]  lo_b, hi_b;
    logic signed [RW-1:0]  n_r [3];

    always_comb begin
        logic signed [WW-1:0] mag;
        mag = '0;
        for (int j = 0; j < 2; j++) begin
            mag    = i_sat[j] ? WEIGHT_CAP : $signed(WW'(i_q[j]));
            n_w[j] = i_neg[j] ? -mag : mag;
        end
    end

    assign lo_b = -$signed(WW'(i_tol));
    assign hi_b = WEIGHT_ONE + $signed(WW'(i_tol));

    // blended sum carries 22 fraction bits; round half up to 8
    always_comb begin
        logic signed [BSW-1:0] sum;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            sum    = BSW'(r3_pa[k]) + BSW'(r3_pb[k]) + BSW'(r3_pl[k]) + BSW'(8192);
            n_r[k] = RW'(sum >>> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[STAGES-2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < STAGES - 1; s++) r_side[s] <= r_side[s-1];

            r1_l <= n_w[0];
            r1_b <= n_w[1];

            r2_l <= r1_l;
            r2_b <= r1_b;
            r2_a <= WEIGHT_ONE - r1_l - r1_b;

            r3_inside <= (r2_a >= lo_b) && (r2_a <= hi_b) && (r2_b >= lo_b)
                      && (r2_b <= hi_b) && (r2_l >= lo_b) && (r2_l <= hi_b);
            for (int k = 0; k < 3; k++) begin
                r3_pa[k] <= BW'(r2_a) * BW'(r_side[1].p0[k]);
                r3_pb[k] <= BW'(r2_b) * BW'(r_side[1].p1[k]);
                r3_pl[k] <= BW'(r2_l) * BW'(r_side[1].p2[k]);
            end

            r4_inside <= r3_inside;
            r4_r      <= n_r;

            r_degen  <= r_side[3].degen;
            r_inside <= r4_inside && !r_side[3].degen;
            for (int k = 0; k < 3; k++) begin
                if (r_side[3].degen) begin
                    r_proj[k] <= '0;
                end else if (r4_r[k] > PROJ_MAX) begin
                    r_proj[k] <= CW'(PROJ_MAX);
                end else if (r4_r[k] < PROJ_MIN) begin
                    r_proj[k] <= CW'(PROJ_MIN);
                end else begin
                    r_proj[k] <= r4_r[k][CW-1:0];
                end
            end
        end
    end

    assign o_valid  = r_vld[STAGES-1];
    assign o_inside = r_inside;
    assign o_proj   = r_proj;
    assign o_degen  = r_degen;

endmodule

[hw/rtl/point_in_triangle_projection_top.sv]
// Barycentric point-in-triangle test with projection onto the triangle plane.
// One request (three Q8.8 vertices and a query point) is taken every clock unless
// the pipeline holds, and passes through 6 stages of vector and dot-product work,
// 32 stages of the restoring divider (an overflow check, then one quotient bit per
// stage, both weights in parallel) and 5 stages of blend, rounding and saturation,
// the last being the output register. The whole pipeline holds while a result waits untaken.
// The tolerance register sits at APB address 0 and resets to 0.
module point_in_triangle_projection_top import pit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pit_in_if.sink      i_req,
    pit_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "point_in_triangle_projection_top_defines.svh"

    localparam logic IDX_TOL = 1'b0;

    logic [15:0] r_tol;
    t_pipe_ctl   ctl_front, ctl_div, ctl_blend;
    logic        en;
    t_side       side_in, side_f, side_d;
    t_coord      query [3];

    logic           f_valid, d_valid;
    logic [NW-1:0]  f_num [2];
    logic           f_neg [2];
    logic [DDW-1:0] f_den;
    logic [QW-1:0]  d_q [2];
    logic           d_sat [2], d_neg [2];
    t_coord         proj [3];

    assign en          = !o_res.valid || o_res.ready;
    assign i_req.ready = en;

    assign ctl_front = '{en: en, valid: i_req.valid};
    assign ctl_div   = '{en: en, valid: f_valid};
    assign ctl_blend = '{en: en, valid: d_valid};

    always_comb begin
        side_in.p0    = '{i_req.vert0_x, i_req.vert0_y, i_req.vert0_z};
        side_in.p1    = '{i_req.vert1_x, i_req.vert1_y, i_req.vert1_z};
        side_in.p2    = '{i_req.vert2_x, i_req.vert2_y, i_req.vert2_z};
        side_in.degen = 1'b0;
        query         = '{i_req.query_x, i_req.query_y, i_req.query_z};
    end

    // config register, written on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (psel && penable && pwrite && paddr[2] == IDX_TOL) begin
            r_tol <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == IDX_TOL) ? {16'b0, r_tol} : '0;

    pit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_front),
        .i_side  (side_in),
        .i_query (query),
        .o_valid (f_valid),
        .o_side  (side_f),
        .o_num   (f_num),
        .o_neg   (f_neg),
        .o_den   (f_den)
    );

    pit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_div),
        .i_side  (side_f),
        .i_num   (f_num),
        .i_neg   (f_neg),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_side  (side_d),
        .o_q     (d_q),
        .o_sat   (d_sat),
        .o_neg   (d_neg)
    );

    pit_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_blend),
        .i_side   (side_d),
        .i_q      (d_q),
        .i_sat    (d_sat),
        .i_neg    (d_neg),
        .i_tol    (r_tol),
        .o_valid  (o_res.valid),
        .o_inside (o_res.inside_res),
        .o_proj   (proj),
        .o_degen  (o_res.degenerate)
    );

    assign o_res.proj_x = proj[0];
    assign o_res.proj_y = proj[1];
    assign o_res.proj_z = proj[2];

    `PIT_ASSERT_IMP(a_degen_zeroes, o_res.valid && o_res.degenerate, !o_res.inside_res && o_res.proj_x == '0 && o_res.proj_y == '0 && o_res.proj_z == '0)
    `PIT_ASSERT_IMP(a_take_frees_input, o_res.valid && o_res.ready, i_req.ready)
    `PIT_ASSERT_NXT(a_tol_write, psel && penable && pwrite && paddr[2] == IDX_TOL, r_tol == $past(pwdata[15:0]))

endmodule

[tb/sv/tb_top.sv]
// Testbench for point_in_triangle_projection_top: directed and random triangle/query requests
// under several APB-written tolerances, checked against an in-bench predictor.
// Depends on pit_pkg and the pit_in_if / pit_out_if interfaces.
module tb_top;
    import pit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 43;
    localparam logic [2:0] ADDR_TOLERANCE = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec_t [3];

    // field order: vert0 xyz, vert1 xyz, vert2 xyz, query xyz
    typedef struct packed {
        logic [11:0][15:0] f;
    } tri_query_t;

    typedef struct packed {
        logic   inside_res;
        t_coord proj_x;
        t_coord proj_y;
        t_coord proj_z;
        logic   degenerate;
    } proj_res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pit_in_if  req_if ();
    pit_out_if res_if ();

    point_in_triangle_projection_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    tri_query_t pending_queries [$];
    proj_res_t  expected_proj [$];
    tri_query_t query_on_bus;
    logic [15:0] tolerance_q = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;

    function automatic vec_t cross_prod(vec_t a, vec_t b);
        vec_t c;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        return c;
    endfunction

    function automatic wide_t dot_prod(vec_t a, vec_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // num / nsq in 2^-14 units, ties away from zero, magnitude capped at 2^31-1
    function automatic logic signed [63:0] bary_weight(wide_t num, wide_t nsq);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] quo;
        neg = num < 0;
        mag = neg ? $unsigned(-num) : $unsigned(num);
        mag = mag << 14;
        quo = (mag + ($unsigned(nsq) >> 1)) / $unsigned(nsq);
        if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
        return neg ? -$signed({1'b0, quo[62:0]}) : $signed({1'b0, quo[62:0]});
    endfunction

    function automatic t_coord blend_coord(logic signed [63:0] a, logic signed [63:0] b,
                                           logic signed [63:0] l, wide_t c0, wide_t c1,
                                           wide_t c2);
        logic signed [63:0] s;
        logic signed [63:0] r;
        s = a * 64'(c0) + b * 64'(c1) + l * 64'(c2);
        r = (s + 64'sd8192) >>> 14;    // round half up
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
        return t_coord'(r[15:0]);
    endfunction

    function automatic proj_res_t predict_projection(tri_query_t q, logic [15:0] tol);
        vec_t p0, p1, p2, u, v, w, n, cu, cb;
        wide_t nsq;
        logic signed [63:0] l, b, a, lo, hi;
        proj_res_t r;
        for (int k = 0; k < 3; k++) begin
            p0[k] = $signed(q.f[k]);
            p1[k] = $signed(q.f[3 + k]);
            p2[k] = $signed(q.f[6 + k]);
            u[k] = p1[k] - p0[k];
            v[k] = p2[k] - p0[k];
            w[k] = wide_t'($signed(q.f[9 + k])) - p0[k];
        end
        n = cross_prod(u, v);
        nsq = dot_prod(n, n);
        r = '0;
        if (nsq == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        cu = cross_prod(u, w);
        cb = cross_prod(w, v);
        l = bary_weight(dot_prod(cu, n), nsq);
        b = bary_weight(dot_prod(cb, n), nsq);
        a = 64'sd16384 - l - b;
        lo = -$signed({48'd0, tol});
        hi = 64'sd16384 + $signed({48'd0, tol});
        r.inside_res = a >= lo && a <= hi && b >= lo && b <= hi && l >= lo && l <= hi;
        r.proj_x = blend_coord(a, b, l, p0[0], p1[0], p2[0]);
        r.proj_y = blend_coord(a, b, l, p0[1], p1[1], p2[1]);
        r.proj_z = blend_coord(a, b, l, p0[2], p1[2], p2[2]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                expected_proj.insert(expected_proj.size(),
                                     predict_projection(query_on_bus, tolerance_q));
            if (!req_if.valid || req_if.ready) begin
                if (pending_queries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    query_on_bus = pending_queries.pop_front();
                    req_if.vert0_x <= query_on_bus.f[0];
                    req_if.vert0_y <= query_on_bus.f[1];
                    req_if.vert0_z <= query_on_bus.f[2];
                    req_if.vert1_x <= query_on_bus.f[3];
                    req_if.vert1_y <= query_on_bus.f[4];
                    req_if.vert1_z <= query_on_bus.f[5];
                    req_if.vert2_x <= query_on_bus.f[6];
                    req_if.vert2_y <= query_on_bus.f[7];
                    req_if.vert2_z <= query_on_bus.f[8];
                    req_if.query_x <= query_on_bus.f[9];
                    req_if.query_y <= query_on_bus.f[10];
                    req_if.query_z <= query_on_bus.f[11];
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        proj_res_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_proj.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    want = expected_proj.pop_front();
                    if (res_if.inside_res !== want.inside_res)
                        report_mismatch("inside_res", res_if.inside_res, want.inside_res);
                    if (res_if.proj_x !== want.proj_x)
                        report_mismatch("proj_x", res_if.proj_x, want.proj_x);
                    if (res_if.proj_y !== want.proj_y)
                        report_mismatch("proj_y", res_if.proj_y, want.proj_y);
                    if (res_if.proj_z !== want.proj_z)
                        report_mismatch("proj_z", res_if.proj_z, want.proj_z);
                    if (res_if.degenerate !== want.degenerate)
                        report_mismatch("degenerate", res_if.degenerate, want.degenerate);
                end
            end
            res_if.ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TOLERANCE) tolerance_q = data[15:0];
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        #1;
        while (pending_queries.size() > 0 || req_if.valid || expected_proj.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    function automatic tri_query_t make_query(int v0[3], int v1[3], int v2[3], int qp[3]);
        tri_query_t t;
        for (int k = 0; k < 3; k++) begin
            t.f[k]     = 16'(v0[k]);
            t.f[3 + k] = 16'(v1[k]);
            t.f[6 + k] = 16'(v2[k]);
            t.f[9 + k] = 16'(qp[k]);
        end
        return t;
    endfunction

    // mostly small triangles with the query near the plane and near the face
    function automatic tri_query_t random_query();
        tri_query_t t;
        int v0[3], v1[3], v2[3], qp[3];
        int r1, r2, span, pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            for (int k = 0; k < 12; k++) t.f[k] = 16'($urandom);
            return t;
        end
        span = (pick < 90) ? 600 : 16000;
        r1 = $urandom_range(320);
        r2 = $urandom_range(320 - r1);
        r1 = r1 - 32;
        r2 = r2 - 32;
        for (int k = 0; k < 3; k++) begin
            v0[k] = $urandom_range(8000) - 4000;
            v1[k] = v0[k] + $urandom_range(2 * span) - span;
            v2[k] = v0[k] + $urandom_range(2 * span) - span;
            qp[k] = v0[k] + (r1 * (v1[k] - v0[k]) + r2 * (v2[k] - v0[k])) / 256
                    + $urandom_range(16) - 8;
        end
        if (pick >= 97) v2 = v1;    // collapsed edge
        return make_query(v0, v1, v2, qp);
    endfunction

    task automatic add_query(tri_query_t t);
        pending_queries.insert(pending_queries.size(), t);
    endtask

    task automatic run_random(int count);
        repeat (count) add_query(random_query());
        wait_drained();
    endtask

    initial begin
        int zero[3] = '{0, 0, 0};
        int ex[3] = '{256, 0, 0};
        int ey[3] = '{0, 256, 0};
        int mid[3] = '{85, 85, 0};
        int outp[3] = '{512, 512, 300};
        int mx[3] = '{32767, 32767, 32767};
        int mn[3] = '{-32768, -32768, -32768};
        int mix1[3] = '{32767, -32768, 0};
        int mix2[3] = '{-32768, 32767, 32767};
        int line2[3] = '{512, 0, 0};
        int edgep[3] = '{128, 0, 0};
        int near_out[3] = '{-2, 130, 0};

        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_if.valid = 1'b0;
        {req_if.vert0_x, req_if.vert0_y, req_if.vert0_z} = '0;
        {req_if.vert1_x, req_if.vert1_y, req_if.vert1_z} = '0;
        {req_if.vert2_x, req_if.vert2_y, req_if.vert2_z} = '0;
        {req_if.query_x, req_if.query_y, req_if.query_z} = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset tolerance of zero
        add_query(make_query(zero, zero, zero, zero));      // degenerate
        add_query(make_query(zero, ex, line2, mid));        // collinear
        add_query(make_query(zero, ex, ey, zero));
        add_query(make_query(zero, ex, ey, ex));
        add_query(make_query(zero, ex, ey, ey));
        add_query(make_query(zero, ex, ey, mid));
        add_query(make_query(zero, ex, ey, edgep));
        add_query(make_query(zero, ex, ey, outp));
        add_query(make_query(zero, ex, ey, near_out));
        add_query(make_query(mx, mn, mix1, mix2));
        add_query(make_query(mn, mx, mix2, mx));
        add_query(make_query(mix1, mix2, mx, mn));
        add_query(make_query(zero, ex, ey, mn));
        add_query(make_query(mn, mix1, mix2, zero));
        wait_drained();

        apb_write(ADDR_TOLERANCE, 32'hFFFF);
        add_query(make_query(zero, ex, ey, near_out));
        add_query(make_query(zero, ex, ey, outp));
        add_query(make_query(mx, mn, mix1, mix2));
        add_query(make_query(mx, mn, mix1, zero));
        wait_drained();
        apb_write(ADDR_TOLERANCE, 32'h0000_0100);
        apb_write(ADDR_UNMAPPED, 32'h0000_7777);    // ignored by the block
        add_query(make_query(zero, ex, ey, near_out));
        add_query(make_query(zero, ex, ey, mid));
        wait_drained();

        send_idle_pct = 16;
        recv_idle_pct = 51;
        apb_write(ADDR_TOLERANCE, 32'h0);
        run_random(250);
        apb_write(ADDR_TOLERANCE, 32'hFFFF);
        run_random(250);

        send_idle_pct = 51;
        recv_idle_pct = 16;
        apb_write(ADDR_TOLERANCE, 32'h0000_0200);
        run_random(250);
        apb_write(ADDR_TOLERANCE, {16'd0, 16'($urandom)});
        run_random(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(ADDR_TOLERANCE, 32'h0000_4000);
        run_random(225);
        apb_write(ADDR_TOLERANCE, {16'd0, 16'($urandom_range(2048))});
        run_random(225);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule
